// File: design/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared constants and types for the vertex transform with perspective divide.
// ----------------------------------------------------------------------------
`default_nettype none

package vtpd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 64;
   localparam int COORD_W   = 32;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int SUM_W     = PROD_W + 2;
   // floor(sum / 2^FRAC_BITS) plus a 32-bit translation, with sign
   localparam int ACC_W     = SUM_W - FRAC_BITS + 1;
   localparam int DIV_STEPS = COORD_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic [ACC_W-1:0]          mag_type;

   typedef struct packed {
      mag_type            rem;
      logic [COORD_W-1:0] num;
      logic [COORD_W-1:0] quo;
      logic               neg;
      logic               ovf;
      logic [COORD_W-1:0] raw;
   } div_lane_type;

   typedef struct packed {
      div_lane_type [2:0] lane;
      mag_type            den;
      logic               wzero;
   } div_data_type;

endpackage

`default_nettype wire

// File: design/vtpd_div.sv
// ----------------------------------------------------------------------------
// vtpd_div
// Restoring divider pipeline: one quotient bit per stage for three lanes
// sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_div
   import vtpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_vld,
   input  div_data_type      in_data,
   output logic              out_vld,
   output div_data_type      out_data
);

   logic         vld_ff  [DIV_STEPS];
   div_data_type data_ff [DIV_STEPS];
   div_data_type data_in [DIV_STEPS];

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      div_data_type src;
      logic         src_vld;
      if (s == 0) begin : g_first
         assign src     = in_data;
         assign src_vld = in_vld;
      end else begin : g_next
         assign src     = data_ff[s-1];
         assign src_vld = vld_ff[s-1];
      end

      always_comb begin
         logic [ACC_W:0] shifted;
         logic           ge;
         data_in[s] = src;
         for (int l = 0; l < 3; l++) begin
            shifted = {src.lane[l].rem, src.lane[l].num[COORD_W-1]};
            ge      = shifted >= {1'b0, src.den};
            data_in[s].lane[l].rem = ge ? ACC_W'(shifted - {1'b0, src.den})
                                        : shifted[ACC_W-1:0];
            data_in[s].lane[l].num = {src.lane[l].num[COORD_W-2:0], 1'b0};
            data_in[s].lane[l].quo = {src.lane[l].quo[COORD_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
         if (en) begin
            data_ff[s] <= data_in[s];
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STEPS-1];
   assign out_data = data_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: design/vertex_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 homogeneous matrix transform of a Q16.16 point with perspective divide.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one point per request, tdata = {pos_z, pos_y, pos_x}.
//  - rsp_ channel: tdata = {out_z, out_y, out_x}, tuser = w_was_zero.
//  - csr_ channel: write matrix registers (index 0..7) while idle;
//    csr_ready is always high, indexes past 7 are dropped.
//  - Throughput: one request per cycle while the output is not stalled.
//    Stages from accept to rsp_tvalid: 1 multiply, 2 sum, 2 setup, 32 divide, 1 output.
//    The 32-stage divider, one quotient bit per stage, sets the depth.
//  - Reset: pipeline empties, matrix returns to the identity.
//  - Stall: when rsp_tvalid is high and rsp_tready low, the whole pipeline
//    holds and req_tready drops; nothing is lost or repeated.
//  - W of zero: x, y, z are saturated to 32 bits and passed undivided,
//    with tuser set.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_perspective_divide
   import vtpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [95:0]          req_tdata,   // pos_x, pos_y, pos_z
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [95:0]               rsp_tdata,   // out_x, out_y, out_z
   output logic                      rsp_tuser,   // w_was_zero
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   localparam logic [CSR_DAT_W-1:0] ONE_LO = CSR_DAT_W'(1) << FRAC_BITS;
   localparam logic [CSR_DAT_W-1:0] ONE_HI = ONE_LO << 32;

   // matrix registers
   logic [CSR_DAT_W-1:0] mat_ff [NUM_REGS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= ONE_LO;
         mat_ff[1] <= '0;
         mat_ff[2] <= ONE_HI;
         mat_ff[3] <= '0;
         mat_ff[4] <= '0;
         mat_ff[5] <= ONE_LO;
         mat_ff[6] <= '0;
         mat_ff[7] <= ONE_HI;
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_REGS)) begin
         mat_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // element (r, c): register r*2 + c/2, odd columns in the high half
   coord_type elem [4][4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            elem[r][c] = (c % 2 == 1) ? mat_ff[r*2 + c/2][63:32]
                                      : mat_ff[r*2 + c/2][31:0];
         end
      end
   end

   // global advance: the output stage is free or being drained
   logic en;
   logic out_vld_ff;
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // stage 1: twelve products
   coord_type               pos [3];
   logic                    s1_vld_ff;
   logic signed [PROD_W-1:0] s1_prod_ff [3][4];

   assign pos[0] = req_tdata[31:0];
   assign pos[1] = req_tdata[63:32];
   assign pos[2] = req_tdata[95:64];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               s1_prod_ff[r][c] <= pos[r] * elem[r][c];
            end
         end
      end
   end

   // stage 2: exact column sums
   logic                    s2_vld_ff;
   logic signed [SUM_W-1:0] s2_sum_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            s2_sum_ff[c] <= SUM_W'(s1_prod_ff[0][c]) + SUM_W'(s1_prod_ff[1][c])
                          + SUM_W'(s1_prod_ff[2][c]);
         end
      end
   end

   // stage 3: floor to FRAC_BITS, add translation row
   logic    s3_vld_ff;
   acc_type s3_acc_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (en) begin
         for (int c = 0; c < 4; c++) begin
            s3_acc_ff[c] <= ACC_W'(s2_sum_ff[c] >>> FRAC_BITS) + ACC_W'(elem[3][c]);
         end
      end
   end

   // stage 4: magnitudes, signs, zero test, saturated pass-through values
   logic               s4_vld_ff;
   mag_type            s4_mag_ff [3];
   mag_type            s4_den_ff;
   logic               s4_neg_ff [3];
   logic               s4_wzero_ff;
   logic [COORD_W-1:0] s4_raw_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            s4_mag_ff[l] <= s3_acc_ff[l][ACC_W-1] ? mag_type'(-s3_acc_ff[l])
                                                 : mag_type'(s3_acc_ff[l]);
            s4_neg_ff[l] <= s3_acc_ff[l][ACC_W-1] ^ s3_acc_ff[3][ACC_W-1];
            if (s3_acc_ff[l][ACC_W-1:COORD_W-1] == '0 ||
                s3_acc_ff[l][ACC_W-1:COORD_W-1] == '1) begin
               s4_raw_ff[l] <= s3_acc_ff[l][COORD_W-1:0];
            end else if (s3_acc_ff[l][ACC_W-1]) begin
               s4_raw_ff[l] <= {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
               s4_raw_ff[l] <= {1'b0, {(COORD_W-1){1'b1}}};
            end
         end
         s4_den_ff   <= s3_acc_ff[3][ACC_W-1] ? mag_type'(-s3_acc_ff[3])
                                             : mag_type'(s3_acc_ff[3]);
         s4_wzero_ff <= s3_acc_ff[3] == '0;
      end
   end

   // stage 5: divider set-up; numerator is mag << FRAC_BITS
   logic         s5_vld_ff;
   div_data_type s5_data_ff;
   div_data_type s5_data_in;

   always_comb begin
      mag_type top;
      s5_data_in.den   = s4_den_ff;
      s5_data_in.wzero = s4_wzero_ff;
      for (int l = 0; l < 3; l++) begin
         top = s4_mag_ff[l] >> (COORD_W - FRAC_BITS);
         s5_data_in.lane[l].rem = top;
         s5_data_in.lane[l].num = {s4_mag_ff[l][COORD_W-FRAC_BITS-1:0],
                                   {FRAC_BITS{1'b0}}};
         s5_data_in.lane[l].quo = '0;
         s5_data_in.lane[l].neg = s4_neg_ff[l];
         s5_data_in.lane[l].ovf = top >= s4_den_ff;
         s5_data_in.lane[l].raw = s4_raw_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= s4_vld_ff;
      end
      if (en) begin
         s5_data_ff <= s5_data_in;
      end
   end

   logic         div_vld;
   div_data_type div_data;

   vtpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s5_vld_ff),
      .in_data  (s5_data_ff),
      .out_vld  (div_vld),
      .out_data (div_data)
   );

   // output stage: sign and saturation
   logic [95:0] out_data_ff;
   logic [95:0] out_data_in;
   logic        out_wzero_ff;

   always_comb begin
      div_lane_type ln;
      for (int l = 0; l < 3; l++) begin
         ln = div_data.lane[l];
         if (div_data.wzero) begin
            out_data_in[l*32 +: 32] = ln.raw;
         end else if (ln.neg) begin
            out_data_in[l*32 +: 32] = (ln.ovf || ln.quo[31]) ? 32'h8000_0000 : -ln.quo;
         end else begin
            out_data_in[l*32 +: 32] = (ln.ovf || ln.quo[31]) ? 32'h7FFF_FFFF : ln.quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= div_vld;
      end
      if (en) begin
         out_data_ff  <= out_data_in;
         out_wzero_ff <= div_data.wzero;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_wzero_ff;

endmodule

`default_nettype wire

// File: design/vtpd_checker.sv
// ----------------------------------------------------------------------------
// vtpd_checker
// Port-level checks for the vertex transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vtpd_checker
   import vtpd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_ready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with output free");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline stalled");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register port not ready");

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex transform with perspective divide:
// points are streamed through several matrix settings with random idle
// bursts on both sides, and every response is checked against a predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import vtpd_pkg::*;

   localparam int LATENCY = 38;
   localparam int QUIET_TAIL = 150;  // last requests go with no idling

   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } point_type;

   typedef struct packed {
      logic [95:0] data;
      logic        wzero;
   } vertex_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   vertex_transform_perspective_divide i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor copy of the matrix registers
   logic [63:0] matrix_regs [NUM_REGS];

   point_type      pending_points[$];
   vertex_out_type expected_vertices[$];
   int  mismatches = 0;
   int  vertices_checked = 0;
   int  wzero_seen = 0;
   int  sent_count = 0;
   int  total_points = 0;
   bit  quiet = 1'b0;
   int  send_idle = 0;
   int  recv_idle = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [63:0] mat_elem(int r, int c);
      logic [63:0] word;
      word = matrix_regs[r * 2 + c / 2];
      return (c % 2) ? $signed(word[63:32]) : $signed(word[31:0]);
   endfunction

   // exact row-vector dot product, floored to FRAC_BITS, plus translation
   function automatic logic signed [79:0] column_sum(point_type p, int c);
      logic signed [79:0] acc;
      acc = $signed(p.x) * mat_elem(0, c) + $signed(p.y) * mat_elem(1, c)
            + $signed(p.z) * mat_elem(2, c);
      return (acc >>> FRAC_BITS) + mat_elem(3, c);
   endfunction

   function automatic logic [31:0] clamp32(logic signed [79:0] v);
      if (v > 80'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -80'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // n * 2^FRAC_BITS / d truncated toward zero, then clamped
   function automatic logic [31:0] scaled_quotient(logic signed [79:0] n,
                                                   logic signed [79:0] d);
      logic signed [127:0] num;
      logic signed [127:0] q;
      num = $signed(n) <<< FRAC_BITS;
      q = num / $signed(d);  // SV division truncates toward zero
      if (q > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (q < -128'sh8000_0000) return 32'h8000_0000;
      return q[31:0];
   endfunction

   function automatic vertex_out_type project_vertex(point_type p);
      logic signed [79:0] s [4];
      vertex_out_type r;
      for (int c = 0; c < 4; c++) s[c] = column_sum(p, c);
      r.wzero = (s[3] == 0);
      for (int c = 0; c < 3; c++)
         r.data[c*32 +: 32] = r.wzero ? clamp32(s[c]) : scaled_quotient(s[c], s[3]);
      return r;
   endfunction

   // ---- request driver: changes at falling edge ----
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_tready) begin
            // request still waiting: hold valid and data
         end else if (send_idle > 0) begin
            send_idle <= send_idle - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && ($urandom_range(0, 7) == 0)) begin
            send_idle <= $urandom_range(1, 10) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_points[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         // response stall bursts
         if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && ($urandom_range(0, 7) == 0)) begin
            recv_idle <= $urandom_range(1, 10) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // accepted request: predict and pop
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_vertices.push_back(project_vertex(point_type'(req_tdata)));
         void'(pending_points.pop_front());
         sent_count <= sent_count + 1;
         if (total_points - sent_count < QUIET_TAIL) quiet <= 1'b1;
      end
   end

   // ---- response monitor ----
   always @(posedge clock) begin
      vertex_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         vertices_checked <= vertices_checked + 1;
         if (rsp_tuser) wzero_seen <= wzero_seen + 1;
         if (expected_vertices.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser !== want.wzero) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("response %0d: expected %h/%b got %h/%b", vertices_checked,
                           want.data, want.wzero, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;  // +-32
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;  // +-2.0
         default: return $urandom;
      endcase
   endfunction

   // matrix write over the register channel; block must be idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NUM_REGS) matrix_regs[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_points.size() > 0 || expected_vertices.size() > 0) && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic queue_points(int n);
      point_type p;
      for (int i = 0; i < n; i++) begin
         p.x = rand_coord();
         p.y = rand_coord();
         p.z = rand_coord();
         pending_points.push_back(p);
      end
   endtask

   initial begin
      point_type p;
      logic [31:0] w_col;
      total_points = 14 + 7 * 150;
      for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
      matrix_regs[0] = 64'h1_0000;
      matrix_regs[2] = 64'h1_0000 << 32;
      matrix_regs[5] = 64'h1_0000;
      matrix_regs[7] = 64'h1_0000 << 32;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, identity matrix: extremes and fractional values
      p = '{32'h0, 32'h0, 32'h0};                      pending_points.push_back(p);
      p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; pending_points.push_back(p);
      p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; pending_points.push_back(p);
      p = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_8000}; pending_points.push_back(p);
      p = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFE_0000}; pending_points.push_back(p);
      drain();

      // w column: z only, so z == 0 gives w == 0 (undivided, flag set)
      write_reg(7, 64'h0);
      write_reg(5, 64'h1_0000_0000_0000 | 64'h1_0000);
      write_reg(8'hFF, 64'hDEAD_BEEF_DEAD_BEEF);  // dropped index
      p = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000}; pending_points.push_back(p);
      p = '{32'h0, 32'h0001_0000, 32'hFFFF_0000}; pending_points.push_back(p);
      p = '{32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000}; pending_points.push_back(p);  // tiny w
      p = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}; pending_points.push_back(p);
      p = '{32'h0002_0000, 32'h0003_0000, 32'h0001_0000}; pending_points.push_back(p);
      p = '{32'hFFFE_0000, 32'h0003_0000, 32'h0001_0000}; pending_points.push_back(p);
      p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; pending_points.push_back(p);
      p = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000}; pending_points.push_back(p);
      p = '{32'h0000_0001, 32'h8000_0000, 32'h8000_0000}; pending_points.push_back(p);
      drain();

      // random phases: every register rewritten, extremes among the values
      for (int ph = 0; ph < 7; ph++) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            if (ph == 0)
               write_reg(CSR_IDX_W'(r), {32'h7FFF_FFFF, 32'h8000_0000});
            else
               write_reg(CSR_IDX_W'(r), {rand_elem(), rand_elem()});
         end
         // three of the seven phases leave w tiny or zero-prone: small w column
         if (ph % 2 == 1) begin
            w_col = $urandom_range(0, 3);
            write_reg(1, {w_col, matrix_regs[1][31:0]});
            write_reg(3, {32'h0, matrix_regs[3][31:0]});
            write_reg(5, {32'h0, matrix_regs[5][31:0]});
            write_reg(7, {32'h0, matrix_regs[7][31:0]});
         end
         queue_points(150);
         drain();
      end

      $display("checked %0d responses (%0d with w zero) over 9 matrix settings",
               vertices_checked, wzero_seen);
      if (mismatches == 0 && expected_vertices.size() == 0) begin
         $display("vertex_transform_perspective_divide: match");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  expected_vertices.size());
         $display("vertex_transform_perspective_divide: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("vertex_transform_perspective_divide: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
design/vtpd_pkg.sv
design/vtpd_div.sv
design/vertex_transform_perspective_divide.sv
design/vtpd_checker.sv
verif/tb_top.sv
